>>> hdl/zfrc_pkg.sv
// ----------------------------------------------------------------------------
// zfrc_pkg
// Shared types and codes for the ZMODEM file receive control block.
// ----------------------------------------------------------------------------
package zfrc_pkg;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  localparam logic [3:0] ERR_LIMIT_DEFAULT = 4'd10;

  // Kind of event on the input stream (carried in tuser)
  typedef enum logic [1:0] {
    MODE_FILE_START = 2'd0,
    MODE_HEADER     = 2'd1,
    MODE_DATA_END   = 2'd2,
    MODE_UNUSED     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    HT_ZFILE   = 3'd0,
    HT_ZNAK    = 3'd1,
    HT_TIMEOUT = 3'd2,
    HT_ZEOF    = 3'd3,
    HT_ZDATA   = 3'd4,
    HT_GARBAGE = 3'd5,
    HT_OTHER   = 3'd6,
    HT_SPARE   = 3'd7
  } hdr_type_t;

  typedef enum logic [2:0] {
    EK_CRCW    = 3'd0,
    EK_CRCQ    = 3'd1,
    EK_CRCG    = 3'd2,
    EK_CRCE    = 3'd3,
    EK_CRC_ERR = 3'd4,
    EK_TIMEOUT = 3'd5,
    EK_CANCEL  = 3'd6,
    EK_SPARE   = 3'd7
  } end_kind_t;

  // Header to send back
  localparam logic [1:0] HDR_NONE = 2'd0;
  localparam logic [1:0] ZRPOS    = 2'd1;
  localparam logic [1:0] ZACK     = 2'd2;

  typedef enum logic [2:0] {
    ST_RUN   = 3'd0,
    ST_DONE  = 3'd1,
    ST_FAIL  = 3'd2,
    ST_SKIP  = 3'd3,
    ST_CLOSE = 3'd4,
    ST_IDLE  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_DATA    = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        header_ok;
    logic [2:0]  header_type;
    logic [31:0] header_position;
    logic [2:0]  end_kind;
    logic [10:0] byte_count;
    logic        write_failed;
    logic        close_failed;
    logic        abort_request;
  } event_t;

  typedef struct packed {
    logic [1:0]  send_header;
    logic [31:0] sent_position;
    logic        send_attention;
    logic        send_xon;
    logic        commit_block;
    logic        flush_block;
    logic [2:0]  status;
  } action_t;

endpackage

>>> hdl/zfrc_step.sv
// ----------------------------------------------------------------------------
// zfrc_step
// Decision logic for one event: next transfer state and the action word.
// ----------------------------------------------------------------------------
module zfrc_step #(
  parameter int MAX_BLOCK     = 1024,
  parameter int POSITION_BITS = 32
) (
  input  zfrc_pkg::event_t           ev,
  input  logic [3:0]                 max_errors,
  input  logic [POSITION_BITS-1:0]   received_bytes,
  input  logic [3:0]                 error_budget,
  input  zfrc_pkg::phase_t           phase,
  output logic [POSITION_BITS-1:0]   received_bytes_next,
  output logic [3:0]                 error_budget_next,
  output zfrc_pkg::phase_t           phase_next,
  output zfrc_pkg::action_t          act
);

  localparam int LIM_W = $clog2(MAX_BLOCK + 1);
  localparam int CMP_W = (LIM_W > 11) ? LIM_W : 11;

  logic [CMP_W-1:0]         count_ext;
  logic [CMP_W-1:0]         count;
  logic                     pos_match;
  logic                     budget_out;
  logic [3:0]               budget_dec;
  logic                     rpos;
  logic                     fail;
  logic [1:0]               hdr;
  logic                     attn;
  logic                     xon;
  logic                     commit;
  logic                     flush;
  zfrc_pkg::status_t        status;

  assign count_ext  = CMP_W'(ev.byte_count);
  assign count      = (count_ext > CMP_W'(MAX_BLOCK)) ? CMP_W'(MAX_BLOCK) : count_ext;
  assign pos_match  = (ev.header_position[POSITION_BITS-1:0] == received_bytes);
  // An error with no budget left fails the transfer
  assign budget_out = (error_budget == 4'd0);
  assign budget_dec = error_budget - 4'd1;

  always_comb begin
    received_bytes_next = received_bytes;
    error_budget_next   = error_budget;
    phase_next          = phase;
    status              = zfrc_pkg::ST_RUN;
    rpos                = 1'b0;
    fail                = 1'b0;
    hdr                 = zfrc_pkg::HDR_NONE;
    attn                = 1'b0;
    xon                 = 1'b0;
    commit              = 1'b0;
    flush               = 1'b0;

    if (ev.mode == zfrc_pkg::MODE_FILE_START) begin
      if (!ev.header_ok) begin
        status     = zfrc_pkg::ST_SKIP;
        phase_next = zfrc_pkg::PH_IDLE;
      end else begin
        received_bytes_next = '0;
        error_budget_next   = max_errors;
        phase_next          = zfrc_pkg::PH_HEADER;
        if (ev.abort_request) fail = 1'b1;
        else                  rpos = 1'b1;
      end
    end else if (phase == zfrc_pkg::PH_IDLE) begin
      status = zfrc_pkg::ST_IDLE;
    end else if (ev.abort_request) begin
      fail = 1'b1;
    end else if (ev.mode == zfrc_pkg::MODE_HEADER && phase == zfrc_pkg::PH_HEADER) begin
      unique case (ev.header_type)
        zfrc_pkg::HT_ZFILE: begin
          phase_next = zfrc_pkg::PH_DISCARD;
        end
        zfrc_pkg::HT_ZNAK, zfrc_pkg::HT_TIMEOUT: begin
          if (budget_out) begin
            fail = 1'b1;
          end else begin
            error_budget_next = budget_dec;
            phase_next        = zfrc_pkg::PH_DISCARD;
          end
        end
        zfrc_pkg::HT_ZEOF: begin
          // ZEOF at a position other than ours is ignored
          if (pos_match) begin
            status     = ev.close_failed ? zfrc_pkg::ST_CLOSE : zfrc_pkg::ST_DONE;
            phase_next = zfrc_pkg::PH_IDLE;
          end
        end
        zfrc_pkg::HT_ZDATA: begin
          if (pos_match) begin
            phase_next = zfrc_pkg::PH_DATA;
          end else if (budget_out) begin
            fail = 1'b1;
          end else begin
            error_budget_next = budget_dec;
            attn              = 1'b1;
            rpos              = 1'b1;
          end
        end
        zfrc_pkg::HT_GARBAGE: begin
          if (budget_out) begin
            fail = 1'b1;
          end else begin
            error_budget_next = budget_dec;
            attn              = 1'b1;
            rpos              = 1'b1;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
    end else if (ev.mode == zfrc_pkg::MODE_DATA_END && phase == zfrc_pkg::PH_DISCARD) begin
      rpos       = 1'b1;
      phase_next = zfrc_pkg::PH_HEADER;
    end else if (ev.mode == zfrc_pkg::MODE_DATA_END && phase == zfrc_pkg::PH_DATA) begin
      unique case (ev.end_kind)
        zfrc_pkg::EK_CRCW, zfrc_pkg::EK_CRCQ, zfrc_pkg::EK_CRCG, zfrc_pkg::EK_CRCE: begin
          error_budget_next = max_errors;
          if (ev.write_failed) begin
            fail = 1'b1;
          end else begin
            commit              = 1'b1;
            received_bytes_next = received_bytes + POSITION_BITS'(count);
            if (ev.end_kind == zfrc_pkg::EK_CRCW || ev.end_kind == zfrc_pkg::EK_CRCQ) begin
              flush = 1'b1;
              hdr   = zfrc_pkg::ZACK;
            end
            if (ev.end_kind == zfrc_pkg::EK_CRCW) xon = 1'b1;
            if (ev.end_kind == zfrc_pkg::EK_CRCW || ev.end_kind == zfrc_pkg::EK_CRCE) begin
              phase_next = zfrc_pkg::PH_HEADER;
            end
          end
        end
        zfrc_pkg::EK_CRC_ERR, zfrc_pkg::EK_TIMEOUT: begin
          if (budget_out) begin
            fail = 1'b1;
          end else begin
            error_budget_next = budget_dec;
            attn              = (ev.end_kind == zfrc_pkg::EK_CRC_ERR);
            rpos              = 1'b1;
            phase_next        = zfrc_pkg::PH_HEADER;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
    end

    if (fail) begin
      status     = zfrc_pkg::ST_FAIL;
      phase_next = zfrc_pkg::PH_IDLE;
      hdr        = zfrc_pkg::HDR_NONE;
      attn       = 1'b0;
      xon        = 1'b0;
      commit     = 1'b0;
      flush      = 1'b0;
    end else if (rpos) begin
      hdr = zfrc_pkg::ZRPOS;
    end
  end

  always_comb begin
    act.send_header    = hdr;
    act.sent_position  = (hdr != zfrc_pkg::HDR_NONE) ? 32'(received_bytes_next) : 32'd0;
    act.send_attention = attn;
    act.send_xon       = xon;
    act.commit_block   = commit;
    act.flush_block    = flush;
    act.status         = status;
  end

endmodule

>>> hdl/zmodem_file_receive_control_core.sv
// ----------------------------------------------------------------------------
// zmodem_file_receive_control_core
// Receiver-side control of one ZMODEM file transfer, one action per event.
// ----------------------------------------------------------------------------
// Each event on the input stream yields exactly one action word on the output
// stream, in order. An event is captured in an input register, decided by a
// short block of logic against the transfer state (byte position, error
// budget, phase), and the action lands in an output register. Throughput is
// one event per clock when the output is not held off; an event waits in the
// input register until the output register is free or drained. Both
// registers advance together, so the state written by one event is seen by
// the very next one. max_errors may be rewritten between transfers; a
// file-start event loads it into the error budget.
// ----------------------------------------------------------------------------
module zmodem_file_receive_control_core #(
  parameter int MAX_BLOCK     = 1024,
  parameter int POSITION_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input events
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [0] header_ok, [3:1] header_type, [35:4] header_position, [38:36] end_kind,
  // [49:39] byte_count, [50] write_failed, [51] close_failed, [52] abort_request
  input  logic [zfrc_pkg::IN_TDATA_W-1:0]      s_tdata,
  // [1:0] mode
  input  logic [1:0]                           s_tuser,
  // Output actions
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [1:0] send_header, [33:2] sent_position, [34] send_attention, [35] send_xon,
  // [36] commit_block, [37] flush_block, [40:38] status
  output logic [zfrc_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // Configuration: max_errors
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [3:0]                           cfg_data
);

  logic                       in_valid;
  zfrc_pkg::event_t           in_ev;
  logic                       advance;

  logic [POSITION_BITS-1:0]   received_bytes;
  logic [POSITION_BITS-1:0]   received_bytes_next;
  logic [3:0]                 error_budget;
  logic [3:0]                 error_budget_next;
  zfrc_pkg::phase_t           phase;
  zfrc_pkg::phase_t           phase_next;
  logic [3:0]                 max_errors;

  zfrc_pkg::action_t          act;
  zfrc_pkg::action_t          out_act;

  // The event register moves on whenever the output register is free or
  // being drained this cycle.
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_ev.mode            <= s_tuser;
      in_ev.header_ok       <= s_tdata[0];
      in_ev.header_type     <= s_tdata[3:1];
      in_ev.header_position <= s_tdata[35:4];
      in_ev.end_kind        <= s_tdata[38:36];
      in_ev.byte_count      <= s_tdata[49:39];
      in_ev.write_failed    <= s_tdata[50];
      in_ev.close_failed    <= s_tdata[51];
      in_ev.abort_request   <= s_tdata[52];
    end
  end

  zfrc_step #(
    .MAX_BLOCK     (MAX_BLOCK),
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .ev                  (in_ev),
    .max_errors          (max_errors),
    .received_bytes      (received_bytes),
    .error_budget        (error_budget),
    .phase               (phase),
    .received_bytes_next (received_bytes_next),
    .error_budget_next   (error_budget_next),
    .phase_next          (phase_next),
    .act                 (act)
  );

  // Transfer state only changes when an event is actually retired
  always_ff @(posedge clk) begin
    if (rst) begin
      received_bytes <= '0;
      error_budget   <= 4'd0;
      phase          <= zfrc_pkg::PH_IDLE;
    end else if (advance) begin
      received_bytes <= received_bytes_next;
      error_budget   <= error_budget_next;
      phase          <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_errors <= zfrc_pkg::ERR_LIMIT_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      max_errors <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_act <= act;
    end
  end

  assign m_tdata = {7'd0,
                    out_act.status,
                    out_act.flush_block,
                    out_act.commit_block,
                    out_act.send_xon,
                    out_act.send_attention,
                    out_act.sent_position,
                    out_act.send_header};

endmodule

>>> hdl/zfrc_checker.sv
// ----------------------------------------------------------------------------
// zfrc_checker
// Port-level checks on the action stream of the receive control block.
// ----------------------------------------------------------------------------
module zfrc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [zfrc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  // A stalled action holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("action changed while stalled");

  // Nothing is presented right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // No header means no position
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == zfrc_pkg::HDR_NONE |-> m_tdata[33:2] == 32'd0)
    else $error("position without header");

  // A failure carries no other action
  a_fail_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[40:38] == zfrc_pkg::ST_FAIL
    |-> m_tdata[1:0] == zfrc_pkg::HDR_NONE && m_tdata[37:34] == 4'd0)
    else $error("action on failure");

  // ZACK only follows a flushed, committed block
  a_zack_commit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == zfrc_pkg::ZACK |-> m_tdata[36] && m_tdata[37])
    else $error("ZACK without flushed commit");

endmodule

bind zmodem_file_receive_control_core zfrc_checker u_zfrc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/sv/zmodem_file_receive_control_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zmodem_file_receive_control_core_test
// Self-checking bench for the ZMODEM receive-side transfer controller.
// ----------------------------------------------------------------------------
// A driver feeds events from a queue and predicts one action per accepted
// transfer. A monitor checks every action against the oldest prediction, field
// by field. Stimulus starts with a short directed walk through the phases, then
// runs mostly well-formed random file transfers, with noise mixed in, under
// several max_errors settings. Both sides idle in random bursts; the receiver
// also holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module zmodem_file_receive_control_core_test;

  localparam int MAX_BLOCK     = 1024;
  localparam int EVENTS_PER_CFG = 125;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [zfrc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic [1:0]                       s_tuser = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [zfrc_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [3:0]                       cfg_data = '0;

  // Events waiting to be offered, actions waiting to come out
  zfrc_pkg::event_t  pending_events[$];
  zfrc_pkg::action_t expected_actions[$];
  zfrc_pkg::event_t  offered_event;
  zfrc_pkg::action_t want_action;

  // Predicted transfer state
  logic [31:0]      rx_position    = '0;
  logic [3:0]       retry_budget   = '0;
  zfrc_pkg::phase_t rx_phase       = zfrc_pkg::PH_IDLE;
  logic [3:0]       cfg_max_errors = zfrc_pkg::ERR_LIMIT_DEFAULT;

  int send_gap        = 0;
  int recv_gap        = 0;
  int events_queued   = 0;
  int events_accepted = 0;
  int mismatch_count  = 0;
  int stall_left      = 0;
  bit stall_done      = 1'b0;
  bit quiet_tail      = 1'b0;

  zmodem_file_receive_control_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // An error either eats one unit of budget or, at zero, kills the transfer.
  function automatic bit spend_error();
    if (retry_budget == 4'd0) return 1'b1;
    retry_budget = retry_budget - 4'd1;
    return 1'b0;
  endfunction

  function automatic zfrc_pkg::action_t predict_action(zfrc_pkg::event_t ev);
    zfrc_pkg::action_t act;
    logic [31:0]       blk_len;
    bit                fail;
    bit                rpos;
    act = '0;
    act.status = zfrc_pkg::ST_RUN;
    fail = 1'b0;
    rpos = 1'b0;
    // oversized subpackets are clipped to the block size
    blk_len = (ev.byte_count > MAX_BLOCK) ? 32'(MAX_BLOCK) : 32'(ev.byte_count);

    if (ev.mode == zfrc_pkg::MODE_FILE_START) begin
      // file start restarts from any phase
      if (!ev.header_ok) begin
        act.status = zfrc_pkg::ST_SKIP;
        rx_phase = zfrc_pkg::PH_IDLE;
      end else begin
        rx_position = '0;
        retry_budget = cfg_max_errors;
        rx_phase = zfrc_pkg::PH_HEADER;
        if (ev.abort_request) fail = 1'b1;
        else rpos = 1'b1;
      end
    end else if (rx_phase == zfrc_pkg::PH_IDLE) begin
      act.status = zfrc_pkg::ST_IDLE;
    end else if (ev.abort_request) begin
      fail = 1'b1;
    end else if (ev.mode == zfrc_pkg::MODE_HEADER && rx_phase == zfrc_pkg::PH_HEADER) begin
      case (ev.header_type)
        zfrc_pkg::HT_ZFILE: rx_phase = zfrc_pkg::PH_DISCARD;
        zfrc_pkg::HT_ZNAK, zfrc_pkg::HT_TIMEOUT: begin
          if (spend_error()) fail = 1'b1;
          else rx_phase = zfrc_pkg::PH_DISCARD;
        end
        zfrc_pkg::HT_ZEOF: begin
          // ZEOF at the wrong offset is dropped silently
          if (ev.header_position == rx_position) begin
            act.status = ev.close_failed ? zfrc_pkg::ST_CLOSE : zfrc_pkg::ST_DONE;
            rx_phase = zfrc_pkg::PH_IDLE;
          end
        end
        zfrc_pkg::HT_ZDATA: begin
          if (ev.header_position == rx_position) begin
            rx_phase = zfrc_pkg::PH_DATA;
          end else if (spend_error()) begin
            fail = 1'b1;
          end else begin
            act.send_attention = 1'b1;
            rpos = 1'b1;
          end
        end
        zfrc_pkg::HT_GARBAGE: begin
          if (spend_error()) begin
            fail = 1'b1;
          end else begin
            act.send_attention = 1'b1;
            rpos = 1'b1;
          end
        end
        default: fail = 1'b1;
      endcase
    end else if (ev.mode == zfrc_pkg::MODE_DATA_END && rx_phase == zfrc_pkg::PH_DISCARD) begin
      rpos = 1'b1;
      rx_phase = zfrc_pkg::PH_HEADER;
    end else if (ev.mode == zfrc_pkg::MODE_DATA_END && rx_phase == zfrc_pkg::PH_DATA) begin
      if (ev.end_kind <= zfrc_pkg::EK_CRCE) begin
        retry_budget = cfg_max_errors;
        if (ev.write_failed) begin
          fail = 1'b1;
        end else begin
          act.commit_block = 1'b1;
          act.flush_block = (ev.end_kind <= zfrc_pkg::EK_CRCQ);
          rx_position = rx_position + blk_len;
          if (ev.end_kind <= zfrc_pkg::EK_CRCQ) act.send_header = zfrc_pkg::ZACK;
          if (ev.end_kind == zfrc_pkg::EK_CRCW) act.send_xon = 1'b1;
          if (ev.end_kind == zfrc_pkg::EK_CRCW || ev.end_kind == zfrc_pkg::EK_CRCE)
            rx_phase = zfrc_pkg::PH_HEADER;
        end
      end else if (ev.end_kind == zfrc_pkg::EK_CRC_ERR ||
                   ev.end_kind == zfrc_pkg::EK_TIMEOUT) begin
        if (spend_error()) begin
          fail = 1'b1;
        end else begin
          act.send_attention = (ev.end_kind == zfrc_pkg::EK_CRC_ERR);
          rpos = 1'b1;
          rx_phase = zfrc_pkg::PH_HEADER;
        end
      end else begin
        fail = 1'b1;
      end
    end
    // everything else (wrong event for the phase, unused mode) is ignored

    if (fail) begin
      act = '0;
      act.status = zfrc_pkg::ST_FAIL;
      rx_phase = zfrc_pkg::PH_IDLE;
    end else if (rpos) begin
      act.send_header = zfrc_pkg::ZRPOS;
    end
    act.sent_position = (act.send_header != zfrc_pkg::HDR_NONE) ? rx_position : '0;
    return act;
  endfunction

  // --------------------------------------------------------------------------
  // Event builders
  // --------------------------------------------------------------------------
  function automatic zfrc_pkg::event_t start_ev(bit ok, bit abort_req);
    zfrc_pkg::event_t ev;
    ev = '0;
    ev.mode = zfrc_pkg::MODE_FILE_START;
    ev.header_ok = ok;
    ev.abort_request = abort_req;
    return ev;
  endfunction

  function automatic zfrc_pkg::event_t header_ev(zfrc_pkg::hdr_type_t kind,
                                                 logic [31:0] pos, bit close_bad);
    zfrc_pkg::event_t ev;
    ev = '0;
    ev.mode = zfrc_pkg::MODE_HEADER;
    ev.header_type = kind;
    ev.header_position = pos;
    ev.close_failed = close_bad;
    return ev;
  endfunction

  function automatic zfrc_pkg::event_t data_ev(zfrc_pkg::end_kind_t kind,
                                               logic [10:0] cnt, bit wr_bad);
    zfrc_pkg::event_t ev;
    ev = '0;
    ev.mode = zfrc_pkg::MODE_DATA_END;
    ev.end_kind = kind;
    ev.byte_count = cnt;
    ev.write_failed = wr_bad;
    return ev;
  endfunction

  // All fields random, unused codes included
  function automatic zfrc_pkg::event_t random_event();
    zfrc_pkg::event_t ev;
    ev.mode            = 2'($urandom_range(0, 3));
    ev.header_ok       = 1'($urandom_range(0, 1));
    ev.header_type     = 3'($urandom_range(0, 7));
    ev.header_position = $urandom;
    ev.end_kind        = 3'($urandom_range(0, 7));
    ev.byte_count      = 11'($urandom_range(0, 2047));
    ev.write_failed    = 1'($urandom_range(0, 1));
    ev.close_failed    = 1'($urandom_range(0, 1));
    ev.abort_request   = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // Mostly short blocks, some full and some oversized
  function automatic logic [10:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return 11'($urandom_range(0, 256));
    if (r < 16) return 11'(MAX_BLOCK);
    if (r < 18) return 11'($urandom_range(1025, 2047));
    return 11'($urandom_range(0, MAX_BLOCK));
  endfunction

  task automatic offer(zfrc_pkg::event_t ev);
    pending_events.push_back(ev);
    events_queued++;
  endtask

  // One file transfer as a real sender would run it, with the odd error
  task automatic queue_transfer();
    logic [31:0]         pos;
    logic [10:0]         cnt;
    zfrc_pkg::end_kind_t kind;
    bit                  wr_bad;
    int                  subs;
    int                  r;
    int                  i;
    pos = '0;
    offer(start_ev($urandom_range(0, 15) != 0, $urandom_range(0, 31) == 0));
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 11))
        0: offer(header_ev(zfrc_pkg::HT_GARBAGE, $urandom, 1'b0));
        1: begin
          offer(header_ev(zfrc_pkg::hdr_type_t'($urandom_range(0, 2)), $urandom, 1'b0));
          offer(data_ev(zfrc_pkg::end_kind_t'($urandom_range(0, 7)), pick_count(), 1'b0));
        end
        2: offer(header_ev(zfrc_pkg::HT_ZDATA, pos + $urandom_range(1, 4096), 1'b0));
        3: offer(random_event());
        default: ;
      endcase
      offer(header_ev(zfrc_pkg::HT_ZDATA, pos, 1'b0));
      subs = $urandom_range(1, 6);
      for (i = 0; i < subs; i++) begin
        r = $urandom_range(0, 19);
        if (i == subs - 1) kind = (r < 10) ? zfrc_pkg::EK_CRCE : zfrc_pkg::EK_CRCW;
        else if (r < 12) kind = zfrc_pkg::EK_CRCG;
        else if (r < 15) kind = zfrc_pkg::EK_CRCQ;
        else if (r < 17) kind = zfrc_pkg::EK_CRC_ERR;
        else if (r < 18) kind = zfrc_pkg::EK_TIMEOUT;
        else if (r < 19) kind = zfrc_pkg::EK_CANCEL;
        else kind = zfrc_pkg::EK_SPARE;
        wr_bad = ($urandom_range(0, 49) == 0);
        cnt = pick_count();
        offer(data_ev(kind, cnt, wr_bad));
        if (kind <= zfrc_pkg::EK_CRCE && !wr_bad)
          pos = pos + ((cnt > MAX_BLOCK) ? 32'(MAX_BLOCK) : 32'(cnt));
        if (kind != zfrc_pkg::EK_CRCG && kind != zfrc_pkg::EK_CRCQ) break;
      end
    end
    if ($urandom_range(0, 4) == 0) offer(header_ev(zfrc_pkg::HT_ZEOF, pos + 1, 1'b0));
    offer(header_ev(zfrc_pkg::HT_ZEOF, pos, $urandom_range(0, 3) == 0));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_events.size() != 0 || s_tvalid || expected_actions.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_max_errors(logic [3:0] value);
    // let the pipeline settle before touching the register
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_max_errors = value;
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: one event per transfer, random idle bursts between them
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_actions.push_back(predict_action(offered_event));
        events_accepted <= events_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          offered_event = pending_events.pop_front();
          s_tdata <= {3'b000, offered_event.abort_request, offered_event.close_failed,
                      offered_event.write_failed, offered_event.byte_count,
                      offered_event.end_kind, offered_event.header_position,
                      offered_event.header_type, offered_event.header_ok};
          s_tuser <= offered_event.mode;
          s_tvalid <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once the run is well under way
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (!stall_done && events_accepted >= 300) begin
      stall_left <= 64;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each action transfer against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_actions.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 40)
            $display("%0t: action expected none actual %0h", $time, m_tdata);
        end else begin
          want_action = expected_actions.pop_front();
          compare_field("send_header", want_action.send_header, m_tdata[1:0]);
          compare_field("sent_position", want_action.sent_position, m_tdata[33:2]);
          compare_field("send_attention", want_action.send_attention, m_tdata[34]);
          compare_field("send_xon", want_action.send_xon, m_tdata[35]);
          compare_field("commit_block", want_action.commit_block, m_tdata[36]);
          compare_field("flush_block", want_action.flush_block, m_tdata[37]);
          compare_field("status", want_action.status, m_tdata[40:38]);
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 8);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    zfrc_pkg::event_t ev;
    logic [3:0]       cfg_plan[6];
    int               phase_start;
    cfg_plan = '{4'd0, 4'd15, 4'($urandom_range(2, 14)), 4'd1, 4'($urandom), 4'd4};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed walk, reset value of max_errors
    offer(header_ev(zfrc_pkg::HT_ZDATA, '0, 1'b0));          // idle: idle status only
    ev = data_ev(zfrc_pkg::EK_CANCEL, '0, 1'b0);
    ev.abort_request = 1'b1;
    offer(ev);                                               // idle ignores abort too
    offer(start_ev(1'b0, 1'b0));                             // skipped file
    offer(start_ev(1'b1, 1'b1));                             // abort on file start
    offer(start_ev(1'b1, 1'b0));                             // ZRPOS 0
    offer(data_ev(zfrc_pkg::EK_CRCG, 11'd5, 1'b0));          // data in header phase
    ev = random_event();
    ev.mode = zfrc_pkg::MODE_UNUSED;
    ev.abort_request = 1'b0;
    offer(ev);                                               // unused mode
    offer(header_ev(zfrc_pkg::HT_ZEOF, 32'hFFFF_FFFF, 1'b1)); // ZEOF at wrong offset
    offer(header_ev(zfrc_pkg::HT_ZFILE, '0, 1'b0));          // to discard
    offer(data_ev(zfrc_pkg::EK_CRCE, 11'd100, 1'b0));        // discard -> ZRPOS
    offer(header_ev(zfrc_pkg::HT_ZNAK, '0, 1'b0));
    offer(data_ev(zfrc_pkg::EK_SPARE, 11'd2047, 1'b1));      // discard takes any kind
    offer(header_ev(zfrc_pkg::HT_GARBAGE, 32'h5A5A_A5A5, 1'b0));
    offer(header_ev(zfrc_pkg::HT_ZDATA, 32'd5, 1'b0));       // position mismatch
    offer(header_ev(zfrc_pkg::HT_ZDATA, '0, 1'b0));          // to data
    offer(header_ev(zfrc_pkg::HT_ZEOF, '0, 1'b0));           // header in data phase
    offer(data_ev(zfrc_pkg::EK_CRCG, 11'd0, 1'b0));
    offer(data_ev(zfrc_pkg::EK_CRCQ, 11'd1024, 1'b0));
    offer(data_ev(zfrc_pkg::EK_CRC_ERR, 11'd77, 1'b0));
    offer(header_ev(zfrc_pkg::HT_ZDATA, 32'd1024, 1'b0));
    offer(data_ev(zfrc_pkg::EK_CRCW, 11'd2047, 1'b0));       // oversized, clipped
    offer(header_ev(zfrc_pkg::HT_ZDATA, 32'd2048, 1'b0));
    offer(data_ev(zfrc_pkg::EK_TIMEOUT, 11'd3, 1'b0));
    offer(header_ev(zfrc_pkg::HT_SPARE, '0, 1'b0));          // unknown header fails
    offer(start_ev(1'b1, 1'b0));
    offer(header_ev(zfrc_pkg::HT_ZEOF, '0, 1'b1));           // close failure
    wait_drained();

    // Random transfers under each max_errors setting; the sender waits for
    // every action before the register moves
    foreach (cfg_plan[p]) begin
      write_max_errors(cfg_plan[p]);
      @(negedge clk);
      if (p == 5) quiet_tail = 1'b1;
      phase_start = events_queued;
      while (events_queued - phase_start < EVENTS_PER_CFG) begin
        if ($urandom_range(0, 5) == 0) offer(random_event());
        else queue_transfer();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
